// ----- rtl/wbvb_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted balancing vector builder package
// Shared types, codes and default sizes for the vector builder.
// ----------------------------------------------------------------------------
package wbvb_pkg;

  // Default sizes.
  localparam int unsigned MaxLocatorsDefault = 32;
  localparam int unsigned WeightBitsDefault  = 8;
  localparam int unsigned SlotDepthDefault   = 16384;

  // Request modes.
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeRead = 1'b1;

  // Vector regions and select codes.
  localparam logic [1:0] VecV4       = 2'd0;
  localparam logic [1:0] VecV6       = 2'd1;
  localparam logic [1:0] VecCombined = 2'd2;

  // Priority value that marks an unused locator.
  localparam logic [7:0] PrioUnused = 8'd255;

  // Combined vector source codes.
  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindV4     = 2'd1;
  localparam logic [1:0] KindV6     = 2'd2;
  localparam logic [1:0] KindMerged = 2'd3;

  typedef struct packed {
    logic        mode;
    logic        family;
    logic [5:0]  locator_id;
    logic [7:0]  priority_req;
    logic [7:0]  weight;
    logic        up;
    logic        last;
    logic [1:0]  vector_select;
    logic [13:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [5:0]  slot_locator;
    logic        slot_valid;
    logic [12:0] v4_length;
    logic [12:0] v6_length;
    logic [13:0] combined_length;
    logic [1:0]  combined_source;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StReadWait,
    StResp,
    StGcdRead,
    StGcdData,
    StGcdRun,
    StFillRead,
    StFillData,
    StFillWrite
  } state_e;

endpackage

// ----- rtl/weighted_balancing_vector_builder.sv -----
// ----------------------------------------------------------------------------
// Weighted balancing vector builder
// Collects locators per family, then builds GCD-reduced weighted slot vectors
// in a slot memory and serves slot reads from it.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  in_i  (wbvb_pkg::req_t)
// out      output     out_valid_o/ out_ready_i out_o (wbvb_pkg::rsp_t)
//
// A load or a read request goes to StResp or StReadWait when it is taken, and
// the response register is loaded from that state; a read's slot memory data
// is registered as the request is taken. The block takes one request at a
// time, and a new one only after the previous response has been accepted.
// A load marked last first runs the build sequencer, for each family and again
// for a merged vector: StGcdRead and StGcdData per candidate plus subtractive
// Euclid steps for the GCD, then StFillRead, StFillData per candidate and
// StFillWrite per slot, through the single candidate read and slot write port.
// Reset is asynchronous and clears control state; memories are not cleared.
// ----------------------------------------------------------------------------
module weighted_balancing_vector_builder #(
  parameter int unsigned MAX_LOCATORS_PER_FAMILY = wbvb_pkg::MaxLocatorsDefault,
  parameter int unsigned WEIGHT_BITS             = wbvb_pkg::WeightBitsDefault,
  parameter int unsigned SLOT_DEPTH              = wbvb_pkg::SlotDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wbvb_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wbvb_pkg::rsp_t out_o
);

  localparam int unsigned CntW  = $clog2(MAX_LOCATORS_PER_FAMILY + 1);
  localparam int unsigned CIdxW = (MAX_LOCATORS_PER_FAMILY > 1) ?
                                  $clog2(MAX_LOCATORS_PER_FAMILY) : 1;
  localparam int unsigned CandDepth = 2 << CIdxW;
  localparam int unsigned SIdxW = $clog2(SLOT_DEPTH);
  localparam int unsigned SlotMemDepth = 3 << SIdxW;
  localparam int unsigned LenW = $clog2(SLOT_DEPTH + 1);
  localparam int unsigned XW   = (LenW > 14) ? LenW : 14;
  localparam int unsigned EntW = 6 + WEIGHT_BITS;

  // Control and datapath registers.
  wbvb_pkg::state_e state_q, state_d;
  logic [CntW-1:0]        cnt_q [2];
  logic [CntW-1:0]        cnt_d [2];
  logic [7:0]             best_q [2];
  logic [7:0]             best_d [2];
  logic [WEIGHT_BITS-1:0] g_q [2];
  logic [WEIGHT_BITS-1:0] g_d [2];
  logic                   nz_q [2];
  logic                   nz_d [2];
  logic [LenW-1:0]        len_q [3];
  logic [LenW-1:0]        len_d [3];
  logic [1:0]             kind_q, kind_d;
  logic                   open_q, open_d;
  logic [1:0]             phase_q, phase_d;
  logic                   fsrc_q, fsrc_d;
  logic [CntW-1:0]        i_q, i_d;
  logic [WEIGHT_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [WEIGHT_BITS-1:0] u_q, u_d, rem_q, rem_d;
  logic                   fnz_q, fnz_d;
  logic [5:0]             id_q, id_d;
  logic [LenW-1:0]        pos_q, pos_d;
  logic                   rvalid_q, rvalid_d;
  logic                   out_valid_q, out_valid_d;
  wbvb_pkg::rsp_t         out_q, out_d;

  // Memories.
  logic [EntW-1:0] cand_mem [CandDepth];
  logic [EntW-1:0] cand_rdata_q;
  logic [5:0]      slot_mem [SlotMemDepth];
  logic [5:0]      slot_rdata_q;

  logic                          cand_we;
  logic [CIdxW:0]                cand_waddr;
  logic [EntW-1:0]               cand_wdata;
  logic [CIdxW:0]                cand_raddr;
  logic                          slot_we;
  logic [SIdxW+1:0]              slot_waddr;
  logic                          slot_re;
  logic [SIdxW+1:0]              slot_raddr;

  logic                   accept;
  logic [CntW-1:0]        base_cnt;
  logic [7:0]             base_best;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [5:0]             rd_id;
  logic [XW-1:0]          idx_x;
  logic [XW-1:0]          sel_len_x;
  logic                   read_hit;
  logic [1:0]             read_region;
  logic                   cnt_end;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == wbvb_pkg::StIdle) && !out_valid_q;
  assign w_in       = WEIGHT_BITS'(in_i.weight);
  assign base_cnt   = open_q ? cnt_q[in_i.family] : '0;
  assign base_best  = open_q ? best_q[in_i.family] : wbvb_pkg::PrioUnused;
  assign rd_w       = cand_rdata_q[WEIGHT_BITS-1:0];
  assign rd_id      = cand_rdata_q[EntW-1:WEIGHT_BITS];
  assign cand_raddr = {fsrc_q, i_q[CIdxW-1:0]};
  assign cnt_end    = (i_q == cnt_q[fsrc_q]);

  // Read decode: bounds check and region selection.
  assign idx_x = XW'(in_i.slot_index);
  always_comb begin
    sel_len_x   = '0;
    read_region = in_i.vector_select;
    case (in_i.vector_select)
      wbvb_pkg::VecV4:       sel_len_x = XW'(len_q[0]);
      wbvb_pkg::VecV6:       sel_len_x = XW'(len_q[1]);
      wbvb_pkg::VecCombined: begin
        sel_len_x = XW'(len_q[2]);
        if (kind_q == wbvb_pkg::KindV4) read_region = wbvb_pkg::VecV4;
        if (kind_q == wbvb_pkg::KindV6) read_region = wbvb_pkg::VecV6;
      end
      default: sel_len_x = '0;
    endcase
  end
  assign read_hit   = (idx_x < sel_len_x) && (idx_x < XW'(SLOT_DEPTH));
  assign slot_re    = accept && (in_i.mode == wbvb_pkg::ModeRead) && read_hit;
  assign slot_raddr = {read_region, idx_x[SIdxW-1:0]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wbvb_pkg::StIdle: begin
        if (accept) begin
          if (in_i.mode == wbvb_pkg::ModeRead) state_d = wbvb_pkg::StReadWait;
          else if (in_i.last) state_d = wbvb_pkg::StGcdRead;
          else state_d = wbvb_pkg::StResp;
        end
      end
      wbvb_pkg::StReadWait: state_d = wbvb_pkg::StIdle;
      wbvb_pkg::StResp:     state_d = wbvb_pkg::StIdle;
      wbvb_pkg::StGcdRead:  state_d = cnt_end ? wbvb_pkg::StFillRead : wbvb_pkg::StGcdData;
      wbvb_pkg::StGcdData:  state_d = (i_q == '0) ? wbvb_pkg::StGcdRead : wbvb_pkg::StGcdRun;
      wbvb_pkg::StGcdRun: begin
        if (b_q == '0) begin
          state_d = (phase_q == wbvb_pkg::VecCombined) ? wbvb_pkg::StFillRead :
                                                         wbvb_pkg::StGcdRead;
        end
      end
      wbvb_pkg::StFillRead: begin
        if (!cnt_end) begin
          state_d = wbvb_pkg::StFillData;
        end else if (!((phase_q == wbvb_pkg::VecCombined) && !fsrc_q)) begin
          if (phase_q == wbvb_pkg::VecV4) begin
            state_d = wbvb_pkg::StGcdRead;
          end else if (phase_q == wbvb_pkg::VecV6 && cnt_q[0] != '0 && cnt_q[1] != '0 &&
                       best_q[0] == best_q[1]) begin
            state_d = wbvb_pkg::StGcdRun;
          end else begin
            state_d = wbvb_pkg::StResp;
          end
        end
      end
      wbvb_pkg::StFillData: state_d = wbvb_pkg::StFillWrite;
      wbvb_pkg::StFillWrite: begin
        if (!((rem_q >= u_q) && (pos_q < LenW'(SLOT_DEPTH)))) begin
          state_d = wbvb_pkg::StFillRead;
        end
      end
      default: state_d = wbvb_pkg::StIdle;
    endcase
  end

  // Datapath, memory strobes and response.
  always_comb begin
    cnt_d       = cnt_q;
    best_d      = best_q;
    g_d         = g_q;
    nz_d        = nz_q;
    len_d       = len_q;
    kind_d      = kind_q;
    open_d      = open_q;
    phase_d     = phase_q;
    fsrc_d      = fsrc_q;
    i_d         = i_q;
    a_d         = a_q;
    b_d         = b_q;
    u_d         = u_q;
    rem_d       = rem_q;
    fnz_d       = fnz_q;
    id_d        = id_q;
    pos_d       = pos_q;
    rvalid_d    = rvalid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cand_we     = 1'b0;
    cand_waddr  = '0;
    cand_wdata  = {in_i.locator_id, w_in};
    slot_we     = 1'b0;
    slot_waddr  = {phase_q, pos_q[SIdxW-1:0]};

    case (state_q)
      wbvb_pkg::StIdle: begin
        if (accept && in_i.mode == wbvb_pkg::ModeRead) begin
          rvalid_d = read_hit;
        end else if (accept) begin
          // A load that opens a set clears the candidate lists first.
          if (!open_q) begin
            cnt_d[0]  = '0;
            cnt_d[1]  = '0;
            best_d[0] = wbvb_pkg::PrioUnused;
            best_d[1] = wbvb_pkg::PrioUnused;
          end
          open_d = !in_i.last;
          if (in_i.up && in_i.priority_req != wbvb_pkg::PrioUnused) begin
            if (in_i.priority_req < base_best) begin
              best_d[in_i.family] = in_i.priority_req;
              cnt_d[in_i.family]  = CntW'(1);
              cand_we             = 1'b1;
              cand_waddr          = {in_i.family, {CIdxW{1'b0}}};
            end else if (in_i.priority_req == base_best &&
                         base_cnt < CntW'(MAX_LOCATORS_PER_FAMILY)) begin
              cnt_d[in_i.family] = base_cnt + CntW'(1);
              cand_we            = 1'b1;
              cand_waddr         = {in_i.family, base_cnt[CIdxW-1:0]};
            end
          end
          // Build start: family v4 first.
          phase_d = wbvb_pkg::VecV4;
          fsrc_d  = 1'b0;
          i_d     = '0;
          nz_d[0] = 1'b0;
          nz_d[1] = 1'b0;
          g_d[0]  = '0;
          g_d[1]  = '0;
        end
      end

      wbvb_pkg::StReadWait: begin
        out_valid_d           = 1'b1;
        out_d.slot_locator    = rvalid_q ? slot_rdata_q : 6'd0;
        out_d.slot_valid      = rvalid_q;
        out_d.v4_length       = 13'(len_q[0]);
        out_d.v6_length       = 13'(len_q[1]);
        out_d.combined_length = 14'(len_q[2]);
        out_d.combined_source = kind_q;
      end

      wbvb_pkg::StResp: begin
        out_valid_d           = 1'b1;
        out_d.slot_locator    = 6'd0;
        out_d.slot_valid      = 1'b0;
        out_d.v4_length       = 13'(len_q[0]);
        out_d.v6_length       = 13'(len_q[1]);
        out_d.combined_length = 14'(len_q[2]);
        out_d.combined_source = kind_q;
      end

      // Family GCD: walk the candidates, folding each weight in.
      wbvb_pkg::StGcdRead: begin
        if (cnt_end) begin
          i_d   = '0;
          pos_d = '0;
          fnz_d = nz_q[phase_q[0]];
          u_d   = nz_q[phase_q[0]] ? g_q[phase_q[0]] : WEIGHT_BITS'(1);
        end
      end

      wbvb_pkg::StGcdData: begin
        if (rd_w != '0) nz_d[phase_q[0]] = 1'b1;
        if (i_q == '0) begin
          g_d[phase_q[0]] = rd_w;
        end else begin
          a_d = g_q[phase_q[0]];
          b_d = rd_w;
        end
        i_d = i_q + CntW'(1);
      end

      // Subtractive Euclid step.
      wbvb_pkg::StGcdRun: begin
        if (b_q == '0) begin
          if (phase_q == wbvb_pkg::VecCombined) begin
            fnz_d  = nz_q[0] || nz_q[1];
            u_d    = (nz_q[0] || nz_q[1]) ? a_q : WEIGHT_BITS'(1);
            i_d    = '0;
            pos_d  = '0;
            fsrc_d = 1'b0;
          end else begin
            g_d[phase_q[0]] = a_q;
          end
        end else if (a_q >= b_q) begin
          a_d = a_q - b_q;
        end else begin
          a_d = b_q;
          b_d = a_q;
        end
      end

      // Fill: one slot per cycle while a candidate's run is written, weight/g slots per candidate.
      wbvb_pkg::StFillRead: begin
        if (cnt_end) begin
          if ((phase_q == wbvb_pkg::VecCombined) && !fsrc_q) begin
            fsrc_d = 1'b1;
            i_d    = '0;
          end else begin
            len_d[phase_q] = pos_q;
            if (phase_q == wbvb_pkg::VecV4) begin
              phase_d = wbvb_pkg::VecV6;
              fsrc_d  = 1'b1;
              i_d     = '0;
            end else if (phase_q == wbvb_pkg::VecV6) begin
              kind_d   = wbvb_pkg::KindNone;
              len_d[2] = '0;
              if (cnt_q[0] != '0 && cnt_q[1] != '0) begin
                if (best_q[0] < best_q[1]) begin
                  kind_d   = wbvb_pkg::KindV4;
                  len_d[2] = len_q[0];
                end else if (best_q[0] > best_q[1]) begin
                  kind_d   = wbvb_pkg::KindV6;
                  len_d[2] = pos_q;
                end else begin
                  phase_d = wbvb_pkg::VecCombined;
                  a_d     = g_q[0];
                  b_d     = g_q[1];
                end
              end
            end else begin
              kind_d = wbvb_pkg::KindMerged;
            end
          end
        end
      end

      wbvb_pkg::StFillData: begin
        id_d  = rd_id;
        rem_d = fnz_q ? rd_w : WEIGHT_BITS'(1);
        i_d   = i_q + CntW'(1);
      end

      wbvb_pkg::StFillWrite: begin
        if ((rem_q >= u_q) && (pos_q < LenW'(SLOT_DEPTH))) begin
          slot_we = 1'b1;
          pos_d   = pos_q + LenW'(1);
          rem_d   = rem_q - u_q;
        end
      end

      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wbvb_pkg::StIdle;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      best_q[0]   <= wbvb_pkg::PrioUnused;
      best_q[1]   <= wbvb_pkg::PrioUnused;
      len_q[0]    <= '0;
      len_q[1]    <= '0;
      len_q[2]    <= '0;
      kind_q      <= wbvb_pkg::KindNone;
      open_q      <= 1'b0;
      phase_q     <= wbvb_pkg::VecV4;
      fsrc_q      <= 1'b0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      best_q      <= best_d;
      len_q       <= len_d;
      kind_q      <= kind_d;
      open_q      <= open_d;
      phase_q     <= phase_d;
      fsrc_q      <= fsrc_d;
      i_q         <= i_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    g_q      <= g_d;
    nz_q     <= nz_d;
    a_q      <= a_d;
    b_q      <= b_d;
    u_q      <= u_d;
    rem_q    <= rem_d;
    fnz_q    <= fnz_d;
    id_q     <= id_d;
    pos_q    <= pos_d;
    rvalid_q <= rvalid_d;
    out_q    <= out_d;
  end

  // Candidate memory: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (cand_we) cand_mem[cand_waddr] <= cand_wdata;
    cand_rdata_q <= cand_mem[cand_raddr];
  end

  // Slot memory: sequencer writes, request reads.
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= id_q;
    if (slot_re) slot_rdata_q <= slot_mem[slot_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A response without a combined vector reports no combined length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.combined_source == wbvb_pkg::KindNone |->
    out_o.combined_length == '0)
    else $error("combined length set without combined vector");

  // The fill position never runs past the slot depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wbvb_pkg::StFillWrite |-> pos_q <= LenW'(SLOT_DEPTH))
    else $error("fill position beyond slot depth");

  // One request at a time: after an accept the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in flight");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted balancing vector builder testbench
// Drives locator loads and slot reads through the valid/ready request
// channel, predicts every response with a slot table model and compares
// each accepted response field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxCand   = wbvb_pkg::MaxLocatorsDefault;
  localparam int unsigned SlotDepth = wbvb_pkg::SlotDepthDefault;

  // Slot table model and response scoreboard.
  class slot_table_model;
    logic [5:0]  cand_id [2][MaxCand];
    int unsigned cand_w  [2][MaxCand];
    int unsigned cand_cnt [2];
    int unsigned best_prio [2];
    logic [5:0]  slots [3][SlotDepth];
    int unsigned vec_len [3];
    logic [1:0]  kind;
    bit          load_open;
    wbvb_pkg::rsp_t resp_q [$];
    int          mismatches;

    function new();
      cand_cnt  = '{0, 0};
      best_prio = '{255, 255};
      vec_len   = '{0, 0, 0};
      kind      = wbvb_pkg::KindNone;
      load_open = 0;
      mismatches = 0;
    endfunction

    function int unsigned gcd_of(int unsigned a, int unsigned b);
      int unsigned r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    // Fill one region from a list of locators; returns the length.
    function int unsigned fill(int dst, logic [5:0] ids[$], int unsigned ws[$],
                               int unsigned total, int unsigned g);
      int unsigned pos;
      int unsigned used;
      pos = 0;
      foreach (ids[i]) begin
        used = (total != 0 && g != 0) ? ws[i] / g : 1;
        for (int unsigned k = 0; k < used && pos < SlotDepth; k++) begin
          slots[dst][pos] = ids[i];
          pos++;
        end
      end
      return pos;
    endfunction

    function void rebuild();
      int unsigned tot [2];
      int unsigned g [2];
      logic [5:0]  ids [$];
      int unsigned ws [$];
      logic [5:0]  all_ids [$];
      int unsigned all_ws [$];
      vec_len = '{0, 0, 0};
      kind = wbvb_pkg::KindNone;
      tot = '{0, 0};
      g = '{0, 0};
      for (int f = 0; f < 2; f++) begin
        if (cand_cnt[f] == 0) continue;
        ids.delete();
        ws.delete();
        g[f] = cand_w[f][0];
        for (int i = 0; i < cand_cnt[f]; i++) begin
          tot[f] += cand_w[f][i];
          g[f] = gcd_of(g[f], cand_w[f][i]);
          ids.push_back(cand_id[f][i]);
          ws.push_back(cand_w[f][i]);
          all_ids.push_back(cand_id[f][i]);
          all_ws.push_back(cand_w[f][i]);
        end
        vec_len[f] = fill(f, ids, ws, tot[f], g[f]);
      end
      if (cand_cnt[0] != 0 && cand_cnt[1] != 0) begin
        if (best_prio[0] < best_prio[1]) begin
          kind = wbvb_pkg::KindV4;
          vec_len[2] = vec_len[0];
        end else if (best_prio[0] > best_prio[1]) begin
          kind = wbvb_pkg::KindV6;
          vec_len[2] = vec_len[1];
        end else begin
          kind = wbvb_pkg::KindMerged;
          vec_len[2] = fill(2, all_ids, all_ws, tot[0] + tot[1], gcd_of(g[0], g[1]));
        end
      end
    endfunction

    // Note one accepted request and queue its expected response.
    function void note_request(wbvb_pkg::req_t r);
      wbvb_pkg::rsp_t e;
      int f;
      int src;
      e = '0;
      f = r.family;
      if (r.mode == wbvb_pkg::ModeLoad) begin
        if (!load_open) begin
          cand_cnt = '{0, 0};
          best_prio = '{255, 255};
          load_open = 1;
        end
        if (r.up && r.priority_req != wbvb_pkg::PrioUnused) begin
          if (r.priority_req < best_prio[f]) begin
            best_prio[f] = r.priority_req;
            cand_id[f][0] = r.locator_id;
            cand_w[f][0] = r.weight;
            cand_cnt[f] = 1;
          end else if (r.priority_req == best_prio[f] && cand_cnt[f] < MaxCand) begin
            cand_id[f][cand_cnt[f]] = r.locator_id;
            cand_w[f][cand_cnt[f]] = r.weight;
            cand_cnt[f]++;
          end
        end
        if (r.last) begin
          rebuild();
          load_open = 0;
        end
      end else if (r.vector_select != 2'd3 && r.slot_index < vec_len[r.vector_select]) begin
        src = r.vector_select;
        if (r.vector_select == wbvb_pkg::VecCombined && kind == wbvb_pkg::KindV4)
          src = wbvb_pkg::VecV4;
        if (r.vector_select == wbvb_pkg::VecCombined && kind == wbvb_pkg::KindV6)
          src = wbvb_pkg::VecV6;
        e.slot_locator = slots[src][r.slot_index];
        e.slot_valid = 1'b1;
      end
      e.v4_length = vec_len[0][12:0];
      e.v6_length = vec_len[1][12:0];
      e.combined_length = vec_len[2][13:0];
      e.combined_source = kind;
      resp_q.push_back(e);
    endfunction

    // Compare one accepted response with the oldest expectation.
    function void check_response(wbvb_pkg::rsp_t a);
      wbvb_pkg::rsp_t e;
      if (resp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", a);
        return;
      end
      e = resp_q.pop_front();
      if (a.slot_locator !== e.slot_locator || a.slot_valid !== e.slot_valid ||
          a.v4_length !== e.v4_length || a.v6_length !== e.v6_length ||
          a.combined_length !== e.combined_length ||
          a.combined_source !== e.combined_source) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  wbvb_pkg::req_t req;
  logic out_valid;
  logic out_ready;
  wbvb_pkg::rsp_t rsp;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold;
  slot_table_model table_model;

  weighted_balancing_vector_builder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (rsp)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on run length.
  initial begin
    #60_000_000;
    $display("[weighted_balancing_vector_builder] ERROR");
    $finish;
  end

  // Response side: random stalls, an optional long hold-off, checking.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) table_model.check_response(rsp);
    end
  end

  // Offer one request, hold it until it is accepted, then withdraw it.
  task automatic send_request(wbvb_pkg::req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_model.note_request(r);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Load one locator; fields unused by a load are randomized.
  task automatic load_locator(bit fam, logic [5:0] id, logic [7:0] prio,
                              logic [7:0] w, bit up, bit last);
    wbvb_pkg::req_t r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    r = raw[$bits(wbvb_pkg::req_t)-1:0];
    r.mode = wbvb_pkg::ModeLoad;
    r.family = fam;
    r.locator_id = id;
    r.priority_req = prio;
    r.weight = w;
    r.up = up;
    r.last = last;
    send_request(r);
  endtask

  // Read one slot; inside the selected vector when in_range is set and it is not empty.
  task automatic read_slot(logic [1:0] sel, bit in_range);
    wbvb_pkg::req_t r;
    logic [63:0] raw;
    int unsigned len;
    raw = {$urandom, $urandom};
    r = raw[$bits(wbvb_pkg::req_t)-1:0];
    r.mode = wbvb_pkg::ModeRead;
    r.vector_select = sel;
    len = (sel == 2'd3) ? 0 : table_model.vec_len[sel];
    if (in_range && len > 0) r.slot_index = 14'($urandom_range(0, len - 1));
    send_request(r);
  endtask

  // One well-formed locator set with random content, then some reads.
  task automatic random_set();
    int unsigned n;
    logic [7:0] prio;
    logic [7:0] w;
    int unsigned p;
    n = $urandom_range(1, 7);
    for (int unsigned i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      prio = (p < 5) ? wbvb_pkg::PrioUnused :
             (p < 12) ? 8'($urandom) : 8'($urandom_range(0, 3));
      p = $urandom_range(0, 99);
      w = (p < 8) ? 8'd0 : (p < 12) ? 8'($urandom) : 8'($urandom_range(1, 12));
      load_locator(1'($urandom_range(0, 1)), 6'($urandom), prio, w,
                   $urandom_range(0, 99) < 90, i == n - 1);
    end
    n = $urandom_range(2, 7);
    for (int unsigned i = 0; i < n; i++)
      read_slot($urandom_range(0, 99) < 8 ? 2'd3 : 2'($urandom_range(0, 2)),
                $urandom_range(0, 99) < 85);
  endtask

  task automatic random_phase(int unsigned count);
    for (int unsigned i = 0; i < count; ) begin
      if ($urandom_range(0, 99) < 10) begin
        // Noise: a stray load with random fields.
        load_locator(1'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom), 1'($urandom));
        i++;
      end else begin
        random_set();
        i += 8;
      end
    end
  endtask

  task automatic wait_drained();
    while (table_model.resp_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    table_model = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    req = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reads of empty vectors, then the special cases.
    read_slot(wbvb_pkg::VecV4, 1'b0);
    read_slot(wbvb_pkg::VecCombined, 1'b0);
    // All weights zero: one slot each; down and unused locators skipped.
    load_locator(1'b0, 6'd5, 8'd0, 8'd0, 1'b1, 1'b0);
    load_locator(1'b0, 6'd63, 8'd0, 8'd0, 1'b1, 1'b0);
    load_locator(1'b0, 6'd9, 8'd0, 8'd7, 1'b0, 1'b0);
    load_locator(1'b1, 6'd1, wbvb_pkg::PrioUnused, 8'd4, 1'b1, 1'b1);
    read_slot(wbvb_pkg::VecV4, 1'b1);
    read_slot(wbvb_pkg::VecV6, 1'b1);
    // Tie with mixed zero and nonzero weights: merged vector.
    load_locator(1'b0, 6'd2, 8'd3, 8'd4, 1'b1, 1'b0);
    load_locator(1'b0, 6'd3, 8'd3, 8'd0, 1'b1, 1'b0);
    load_locator(1'b1, 6'd4, 8'd3, 8'd6, 1'b1, 1'b1);
    read_slot(wbvb_pkg::VecCombined, 1'b1);
    read_slot(wbvb_pkg::VecCombined, 1'b1);
    // IPv4 better, then IPv6 better; a better priority restarts the list.
    load_locator(1'b0, 6'd10, 8'd1, 8'd2, 1'b1, 1'b0);
    load_locator(1'b1, 6'd11, 8'd8, 8'd3, 1'b1, 1'b1);
    read_slot(wbvb_pkg::VecCombined, 1'b1);
    load_locator(1'b0, 6'd12, 8'd254, 8'd255, 1'b1, 1'b0);
    load_locator(1'b1, 6'd13, 8'd9, 8'd5, 1'b1, 1'b0);
    load_locator(1'b1, 6'd14, 8'd0, 8'd128, 1'b1, 1'b1);
    read_slot(wbvb_pkg::VecCombined, 1'b1);
    read_slot(wbvb_pkg::VecV4, 1'b0);
    // Full candidate lists, IPv4 at maximum weight, tied, with one extra IPv4 locator ignored.
    for (int i = 0; i < 33; i++) load_locator(1'b0, 6'(i), 8'd7, 8'd255, 1'b1, 1'b0);
    for (int i = 0; i < 31; i++)
      load_locator(1'b1, 6'(i + 32), 8'd7, 8'(255 - i), 1'b1, 1'b0);
    load_locator(1'b1, 6'd63, 8'd7, 8'd1, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) read_slot(2'(i % 3), 1'b1);
    wait_drained();

    // Random phases with different stall patterns.
    send_idle_pct = 13;
    recv_idle_pct = 85;
    random_phase(420);
    send_idle_pct = 85;
    recv_idle_pct = 13;
    random_phase(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 400;
    random_phase(420);

    wait_drained();
    repeat (40) @(posedge clk);
    if (table_model.mismatches == 0 && table_model.resp_q.size() == 0) begin
      $display("[weighted_balancing_vector_builder] OK");
    end else begin
      $display("[weighted_balancing_vector_builder] ERROR");
    end
    $finish;
  end
endmodule
